// File: hdl/sorted_priority_queue_top_macros.svh
// assertion macros shared by the queue rtl
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/spq_pkg.sv
// package for the sorted priority queue: codes, payload types, defaults
package spq_pkg;

  // default sizing
  localparam int DEF_QUEUE_DEPTH    = 16;
  localparam int DEF_NODE_ID_WIDTH  = 16;
  localparam int DEF_PRIORITY_WIDTH = 32;

  // fixed payload field widths
  localparam int OP_W       = 2;
  localparam int IN_NODE_W  = 16;
  localparam int IN_PRI_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int OUT_NODE_W = 16;
  localparam int COUNT_W    = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // input transaction
  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [IN_NODE_W-1:0] node_id;
    logic [IN_PRI_W-1:0]  priority_req;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [OUT_NODE_W-1:0] out_node_id;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    entry_count;
  } out_item_t;

  // broadcast command to every cell, already qualified
  typedef struct packed {
    logic do_insert;
    logic do_pop;
    logic do_remove;
  } cell_cmd_t;

endpackage

// File: hdl/spq_cell.sv
// one slot of the sorted chain: holds an entry and shifts with its neighbours
module spq_cell
  import spq_pkg::*;
#(
  parameter int NODE_W = DEF_NODE_ID_WIDTH,
  parameter int PRI_W  = DEF_PRIORITY_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_cmd_t         cmd,
  input  logic [NODE_W-1:0] new_node,
  input  logic [PRI_W-1:0]  new_pri,
  input  logic              rem_take,
  input  logic              left_gt,
  input  logic              left_valid,
  input  logic [NODE_W-1:0] left_node,
  input  logic [PRI_W-1:0]  left_pri,
  input  logic              right_valid,
  input  logic [NODE_W-1:0] right_node,
  input  logic [PRI_W-1:0]  right_pri,
  output logic              valid,
  output logic [NODE_W-1:0] node,
  output logic [PRI_W-1:0]  pri,
  output logic              gt,
  output logic              match
);

  logic              valid_r, valid_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [PRI_W-1:0]  pri_r, pri_nxt;

  // slot lies past the insertion point (free or strictly later priority)
  assign gt    = !valid_r || (pri_r > new_pri);
  assign match = valid_r && (node_r == new_node);

  // next slot contents
  always_comb begin
    valid_nxt = valid_r;
    node_nxt  = node_r;
    pri_nxt   = pri_r;
    if (cmd.do_insert) begin
      if (left_gt) begin
        valid_nxt = left_valid;
        node_nxt  = left_node;
        pri_nxt   = left_pri;
      end else if (gt) begin
        valid_nxt = 1'b1;
        node_nxt  = new_node;
        pri_nxt   = new_pri;
      end
    end else if (cmd.do_pop || (cmd.do_remove && rem_take)) begin
      valid_nxt = right_valid;
      node_nxt  = right_node;
      pri_nxt   = right_pri;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    pri_r  <= pri_nxt;
  end

  assign valid = valid_r;
  assign node  = node_r;
  assign pri   = pri_r;

endmodule

// File: hdl/sorted_priority_queue_top.sv
// Minimum-first priority queue of node identifiers held as a chain of sorted
// slots. One transaction is taken on every clock (busy stays low) and its
// result appears on the out_ ports in the next cycle, strobed by out_valid
// for exactly one cycle; the receiver cannot stall, so it must take every
// result as it comes. Every slot compares against the request in parallel
// and shifts towards or away from its neighbour in the same cycle, so
// insert, pop and remove all complete in the same way, at any depth.
// Ties leave in arrival order; reset empties the queue at once.
`include "sorted_priority_queue_top_macros.svh"

module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
  parameter int NODE_ID_WIDTH  = DEF_NODE_ID_WIDTH,
  parameter int PRIORITY_WIDTH = DEF_PRIORITY_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [QUEUE_DEPTH-1:0]   cell_valid, cell_gt, cell_match, rem_take;
  logic [NODE_ID_WIDTH-1:0] cell_node [QUEUE_DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_pri [QUEUE_DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r, out_item_nxt;
  cell_cmd_t        cmd;
  logic             accept, full, empty, found;
  logic [63:0]      id_ext, pri_ext, pop_ext, cnt_ext;
  logic [NODE_ID_WIDTH-1:0]  req_node;
  logic [PRIORITY_WIDTH-1:0] req_pri;

  // the chain never stalls the requester
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // request fields fitted to the stored widths
  assign id_ext   = 64'(in_item.node_id);
  assign pri_ext  = 64'(in_item.priority_req);
  assign req_node = id_ext[NODE_ID_WIDTH-1:0];
  assign req_pri  = pri_ext[PRIORITY_WIDTH-1:0];

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign found = |cell_match;

  // qualified command broadcast to the cells
  always_comb begin
    cmd.do_insert = accept && (in_item.operation == OP_INSERT) && !full;
    cmd.do_pop    = accept && (in_item.operation == OP_POP) && !empty;
    cmd.do_remove = accept && (in_item.operation == OP_REMOVE) && found;
  end

  // remove shifts every slot at or after the first match
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rem_take[i] = |(cell_match & ({QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i)));
    end
  end

  // chain of slots
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                      l_gt, l_valid, r_valid;
    logic [NODE_ID_WIDTH-1:0]  l_node, r_node;
    logic [PRIORITY_WIDTH-1:0] l_pri, r_pri;

    if (g == 0) begin : g_head
      assign l_gt    = 1'b0;
      assign l_valid = 1'b0;
      assign l_node  = '0;
      assign l_pri   = '0;
    end else begin : g_mid
      assign l_gt    = cell_gt[g-1];
      assign l_valid = cell_valid[g-1];
      assign l_node  = cell_node[g-1];
      assign l_pri   = cell_pri[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_node  = '0;
      assign r_pri   = '0;
    end else begin : g_body
      assign r_valid = cell_valid[g+1];
      assign r_node  = cell_node[g+1];
      assign r_pri   = cell_pri[g+1];
    end

    spq_cell #(
      .NODE_W (NODE_ID_WIDTH),
      .PRI_W  (PRIORITY_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .new_node    (req_node),
      .new_pri     (req_pri),
      .rem_take    (rem_take[g]),
      .left_gt     (l_gt),
      .left_valid  (l_valid),
      .left_node   (l_node),
      .left_pri    (l_pri),
      .right_valid (r_valid),
      .right_node  (r_node),
      .right_pri   (r_pri),
      .valid       (cell_valid[g]),
      .node        (cell_node[g]),
      .pri         (cell_pri[g]),
      .gt          (cell_gt[g]),
      .match       (cell_match[g])
    );
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_insert) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.do_pop || cmd.do_remove) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // result transaction contents
  assign pop_ext = 64'(cell_node[0]);
  assign cnt_ext = 64'(count_nxt);

  always_comb begin
    out_item_nxt.out_node_id = '0;
    out_item_nxt.status      = ST_DONE;
    out_item_nxt.entry_count = cnt_ext[COUNT_W-1:0];
    case (in_item.operation)
      OP_INSERT: begin
        if (full) out_item_nxt.status = ST_FULL;
      end
      OP_POP: begin
        if (empty) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          out_item_nxt.out_node_id = pop_ext[OUT_NODE_W-1:0];
        end
      end
      OP_REMOVE: begin
        if (!found) out_item_nxt.status = ST_NOT_FOUND;
      end
      default: begin
        out_item_nxt.status = ST_DONE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
  `SPQ_ASSERT_NOW(a_count_match, 1'b1, $countones(cell_valid) == int'(count_r), "occupancy differs from valid slots")
  `SPQ_ASSERT_NOW(a_packed, 1'b1, ((cell_valid >> 1) & ~cell_valid) == '0, "valid slots not packed from the head")
  `SPQ_ASSERT_NEXT(a_result_follows, accept, out_valid, "accepted transaction gave no result")
  `SPQ_ASSERT_NOW(a_no_stray_result, out_valid, $past(accept), "result without accepted transaction")

endmodule
